// File: src/mcew_pkg.sv
// Package for the multi-channel escalating watchdog.
// Holds request kinds, result actions, slot entry and result types.
// No dependencies.
`default_nettype none

package mcew_pkg;

  localparam int unsigned MaxRes = 8;

  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_FEED   = 3'd1,
    KIND_ATTACH = 3'd2,
    KIND_DETACH = 3'd3,
    KIND_QUERY  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_DONE    = 3'd1,
    ACT_MISS    = 3'd2,
    ACT_STEP    = 3'd3,
    ACT_RESTART = 3'd4,
    ACT_SYSRST  = 3'd5
  } action_e;

  typedef struct packed {
    logic [7:0]  client;
    logic [31:0] reload;
    logic [31:0] remaining;
    logic        critical;
    logic [3:0]  recov;
  } entry_t;

  typedef struct packed {
    logic [2:0] slot;
    logic [7:0] client_id_res;
    action_e    action;
    logic [3:0] recovery_count;
    logic       last;
  } result_t;

  typedef struct packed {
    logic    load;
    result_t data;
  } out_ctl_t;

endpackage

`default_nettype wire

// File: src/mcew_if.sv
// Handshake channel interfaces of the watchdog: request, result and config.
// Depends on nothing; payloads are plain vectors.
`default_nettype none

interface mcew_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  client_id;
  logic [31:0] reload_time;
  logic        critical;
  logic [7:0]  stopped_mask;

  modport source (output valid, kind, client_id, reload_time, critical, stopped_mask,
                  input ready);
  modport sink   (input valid, kind, client_id, reload_time, critical, stopped_mask,
                  output ready);
endinterface

interface mcew_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] slot;
  logic [7:0] client_id_res;
  logic [2:0] action;
  logic [3:0] recovery_count;
  logic       last;

  modport source (output valid, slot, client_id_res, action, recovery_count, last,
                  input ready);
  modport sink   (input valid, slot, client_id_res, action, recovery_count, last,
                  output ready);
endinterface

interface mcew_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: src/mcew_out_reg.sv
// Result output register of the watchdog.
// Depends on mcew_pkg and mcew_out_if.
`default_nettype none

module mcew_out_reg (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  mcew_pkg::out_ctl_t ctl_i,
  output logic              free_o,
  mcew_out_if.source        out_o
);
  import mcew_pkg::*;

  logic    vld_q;
  result_t data_q;

  assign free_o = !vld_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.load) begin
      vld_q <= 1'b1;
    end else if (out_o.ready) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      data_q <= ctl_i.data;
    end
  end

  assign out_o.valid          = vld_q;
  assign out_o.slot           = data_q.slot;
  assign out_o.client_id_res  = data_q.client_id_res;
  assign out_o.action         = data_q.action;
  assign out_o.recovery_count = data_q.recovery_count;
  assign out_o.last           = data_q.last;

endmodule

`default_nettype wire

// File: src/multi_channel_escalating_watchdog.sv
// Top level of the multi-channel escalating watchdog: slot table and sequencer.
// Depends on mcew_pkg, mcew_if and mcew_out_reg.
`default_nettype none

// Each request walks the slot table one slot at a time through a single-port
// table memory: a slot is read in ST_RD and evaluated and written back in ST_EV,
// and the request ends in ST_FIN with its final result; feed, detach and query
// stop at the first matching slot, attach at the first free slot. A tick that
// reports several events also waits while the output register still holds an
// earlier transaction. Results of a tick are held one behind so the final one
// can carry last. No clearing pass after reset: slot valid bits are flip-flops
// cleared by reset and by a system reset event.
module multi_channel_escalating_watchdog #(
  parameter int unsigned SLOTS = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  mcew_cfg_if.sink    cfg_i,
  mcew_in_if.sink     in_i,
  mcew_out_if.source  out_o
);
  import mcew_pkg::*;

  localparam int unsigned SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SlotW-1:0] LastIdx = SlotW'(SLOTS - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_EV   = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [3:0] limit_q;

  logic [2:0]  kind_q;
  logic [7:0]  id_q;
  logic [31:0] rt_q;
  logic        crit_q;
  logic [7:0]  stop_q;

  logic [SlotW-1:0] idx_q, idx_d;
  logic [SlotW+2:0] idx_ext;
  logic [SLOTS-1:0] valid_q, valid_d;

  entry_t mem [SLOTS];
  entry_t rd_q;
  entry_t wdata;
  logic   we;

  result_t pend_q, pend_d;
  logic    pend_v_q, pend_v_d;
  logic [3:0] n_q, n_d;

  logic    cur_v, hit, stop_bit, emit_ok;
  logic    ev, sysrst, done, stall, act;
  result_t ev_res;
  logic [31:0] rem_dec;
  out_ctl_t    octl;
  logic        out_free;
  logic        in_acc;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 4'd3;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= in_i.kind;
      id_q   <= in_i.client_id;
      rt_q   <= in_i.reload_time;
      crit_q <= in_i.critical;
      stop_q <= in_i.stopped_mask;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[idx_q] <= wdata;
    end
    if (state_q == ST_RD) begin
      rd_q <= mem[idx_q];
    end
  end

  assign idx_ext  = {3'b000, idx_q};
  assign cur_v    = valid_q[idx_q];
  assign hit      = cur_v && (rd_q.client == id_q);
  assign stop_bit = (idx_ext[SlotW+2:3] == '0) && stop_q[idx_ext[2:0]];
  assign emit_ok  = (n_q != 4'(MaxRes));
  assign rem_dec  = rd_q.remaining - {31'd0, (rd_q.remaining != 32'd0)};

  always_comb begin
    wdata   = rd_q;
    ev      = 1'b0;
    sysrst  = 1'b0;
    done    = 1'b0;
    ev_res  = '{slot: idx_ext[2:0], client_id_res: rd_q.client, action: ACT_DONE,
                recovery_count: 4'd0, last: 1'b0};
    we      = 1'b0;
    valid_d = valid_q;
    case (kind_q)
      KIND_TICK: begin
        if (cur_v) begin
          we = 1'b1;
          wdata.remaining = rem_dec;
          if (rem_dec == 32'd0) begin
            if (rd_q.recov == limit_q) begin
              if (rd_q.critical) begin
                ev     = 1'b1;
                sysrst = 1'b1;
                we     = 1'b0;
                ev_res.action         = ACT_SYSRST;
                ev_res.recovery_count = rd_q.recov;
                valid_d = '0;
              end else if (!stop_bit) begin
                ev = 1'b1;
                wdata.remaining = rd_q.reload;
                wdata.recov     = 4'd0;
                ev_res.action   = ACT_RESTART;
              end
            end else begin
              ev = 1'b1;
              wdata.remaining = {1'b0, rd_q.reload[31:1]};
              wdata.recov     = rd_q.recov + 4'd1;
              ev_res.action         = ACT_STEP;
              ev_res.recovery_count = rd_q.recov + 4'd1;
            end
          end
        end
      end
      KIND_FEED: begin
        if (hit) begin
          we   = 1'b1;
          done = 1'b1;
          wdata.remaining = rd_q.reload;
          wdata.recov     = 4'd0;
        end
      end
      KIND_ATTACH: begin
        if (!cur_v) begin
          we   = 1'b1;
          done = 1'b1;
          wdata = '{client: id_q, reload: rt_q, remaining: rt_q, critical: crit_q,
                    recov: 4'd0};
          valid_d[idx_q] = 1'b1;
          ev_res.client_id_res = id_q;
        end
      end
      KIND_DETACH: begin
        if (hit) begin
          done = 1'b1;
          valid_d[idx_q] = 1'b0;
        end
      end
      KIND_QUERY: begin
        if (hit) begin
          done = 1'b1;
          ev_res.recovery_count = rd_q.recov;
        end
      end
      default: ;
    endcase
    stall = ev && emit_ok && pend_v_q && !out_free;
    act   = (state_q == ST_EV) && !stall;
    if (!act) begin
      we      = 1'b0;
      valid_d = valid_q;
    end
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    n_d      = n_q;
    octl     = '{load: 1'b0, data: pend_q};
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          idx_d  = '0;
          n_d    = 4'd0;
          pend_d = '{slot: 3'd0, client_id_res: in_i.client_id, action: ACT_MISS,
                     recovery_count: 4'd0, last: 1'b0};
          unique case (in_i.kind) inside
            KIND_TICK: begin
              pend_v_d = 1'b0;
              state_d  = ST_RD;
            end
            KIND_FEED, KIND_ATTACH, KIND_DETACH, KIND_QUERY: begin
              pend_v_d = 1'b1;
              state_d  = ST_RD;
            end
            default: begin
              pend_v_d = 1'b0;
              state_d  = ST_FIN;
            end
          endcase
        end
      end
      ST_RD: begin
        state_d = ST_EV;
      end
      ST_EV: begin
        if (act) begin
          if (ev && emit_ok) begin
            n_d = n_q + 4'd1;
            pend_d   = ev_res;
            pend_v_d = 1'b1;
            if (pend_v_q) begin
              octl.load = 1'b1;
            end
          end else if (done) begin
            pend_d = ev_res;
          end
          if (sysrst || done || (idx_q == LastIdx)) begin
            state_d = ST_FIN;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_RD;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          octl.load = 1'b1;
          if (!pend_v_q) begin
            octl.data = '{slot: 3'd0, client_id_res: 8'd0, action: ACT_NONE,
                          recovery_count: 4'd0, last: 1'b0};
          end
          octl.data.last = 1'b1;
          pend_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      valid_q  <= '0;
      pend_v_q <= 1'b0;
      n_q      <= 4'd0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      valid_q  <= valid_d;
      pend_v_q <= pend_v_d;
      n_q      <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  mcew_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (octl),
    .free_o (out_free),
    .out_o  (out_o)
  );

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= 4'(MaxRes))
    else $error("tick result count beyond cap");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_v_q)
    else $error("pending result left over in idle");

  a_fin_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_free) |=> (out_o.valid && out_o.last))
    else $error("final transaction not presented");

  a_sysrst_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act && sysrst) |=> (valid_q == '0 && state_q == ST_FIN))
    else $error("system reset did not clear the table");

endmodule

`default_nettype wire
